// ===== src/arx_pkg.sv =====
package arx_pkg;

	localparam int COORD_FRAC_BITS = 8;
	localparam int TRIG_FRAC_BITS  = 16;

	localparam int ANGLE_W = 11;
	localparam int COORD_W = 24;
	localparam int OUT_W   = 17;
	localparam int AOFF_W  = 12;
	localparam int DEG_W   = 9;
	localparam int IDX_W   = 7;

	localparam int DEG_QUARTER = 90;
	localparam int DEG_HALF    = 2 * DEG_QUARTER;
	localparam int DEG_THREEQ  = 3 * DEG_QUARTER;
	localparam int DEG_FULL    = 4 * DEG_QUARTER;
	localparam int ANGLE_BIAS  = 3 * DEG_FULL;

	localparam int TRIG_MAG_W = TRIG_FRAC_BITS + 1;
	localparam int TRIG_W     = TRIG_MAG_W + 1;
	localparam int TRIG_UP    = (TRIG_FRAC_BITS >= 16) ? TRIG_FRAC_BITS - 16 : 0;
	localparam int TRIG_DN    = (TRIG_FRAC_BITS < 16) ? 16 - TRIG_FRAC_BITS : 1;

	localparam int PROD_W = COORD_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int FRAC_W = COORD_FRAC_BITS + TRIG_FRAC_BITS;
	localparam int RND_W  = SUM_W + 1 - FRAC_W;
	localparam int CMP_W  = RND_W + OUT_W;

	localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
	localparam int OUT_MIN_MAG = 2 ** (OUT_W - 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [OUT_W-1:0] res_t;

	typedef struct packed {
		logic   vld;
		trig_t  sin_v;
		trig_t  cos_v;
		coord_t x;
		coord_t y;
	} arx_trig_t;

	typedef struct packed {
		logic vld;
		sum_t sum_x;
		sum_t sum_y;
	} arx_sum_t;

	function automatic logic [16:0] quarter_sine(input logic [IDX_W-1:0] k);
		logic [16:0] v;
		case (k)
			7'd0: v = 17'd0;
			7'd1: v = 17'd1144;
			7'd2: v = 17'd2287;
			7'd3: v = 17'd3430;
			7'd4: v = 17'd4572;
			7'd5: v = 17'd5712;
			7'd6: v = 17'd6850;
			7'd7: v = 17'd7987;
			7'd8: v = 17'd9121;
			7'd9: v = 17'd10252;
			7'd10: v = 17'd11380;
			7'd11: v = 17'd12505;
			7'd12: v = 17'd13626;
			7'd13: v = 17'd14742;
			7'd14: v = 17'd15855;
			7'd15: v = 17'd16962;
			7'd16: v = 17'd18064;
			7'd17: v = 17'd19161;
			7'd18: v = 17'd20252;
			7'd19: v = 17'd21336;
			7'd20: v = 17'd22415;
			7'd21: v = 17'd23486;
			7'd22: v = 17'd24550;
			7'd23: v = 17'd25607;
			7'd24: v = 17'd26656;
			7'd25: v = 17'd27697;
			7'd26: v = 17'd28729;
			7'd27: v = 17'd29753;
			7'd28: v = 17'd30767;
			7'd29: v = 17'd31772;
			7'd30: v = 17'd32768;
			7'd31: v = 17'd33754;
			7'd32: v = 17'd34729;
			7'd33: v = 17'd35693;
			7'd34: v = 17'd36647;
			7'd35: v = 17'd37590;
			7'd36: v = 17'd38521;
			7'd37: v = 17'd39441;
			7'd38: v = 17'd40348;
			7'd39: v = 17'd41243;
			7'd40: v = 17'd42126;
			7'd41: v = 17'd42995;
			7'd42: v = 17'd43852;
			7'd43: v = 17'd44695;
			7'd44: v = 17'd45525;
			7'd45: v = 17'd46341;
			7'd46: v = 17'd47143;
			7'd47: v = 17'd47930;
			7'd48: v = 17'd48703;
			7'd49: v = 17'd49461;
			7'd50: v = 17'd50203;
			7'd51: v = 17'd50931;
			7'd52: v = 17'd51643;
			7'd53: v = 17'd52339;
			7'd54: v = 17'd53020;
			7'd55: v = 17'd53684;
			7'd56: v = 17'd54332;
			7'd57: v = 17'd54963;
			7'd58: v = 17'd55578;
			7'd59: v = 17'd56175;
			7'd60: v = 17'd56756;
			7'd61: v = 17'd57319;
			7'd62: v = 17'd57865;
			7'd63: v = 17'd58393;
			7'd64: v = 17'd58903;
			7'd65: v = 17'd59396;
			7'd66: v = 17'd59870;
			7'd67: v = 17'd60326;
			7'd68: v = 17'd60764;
			7'd69: v = 17'd61183;
			7'd70: v = 17'd61584;
			7'd71: v = 17'd61966;
			7'd72: v = 17'd62328;
			7'd73: v = 17'd62672;
			7'd74: v = 17'd62997;
			7'd75: v = 17'd63303;
			7'd76: v = 17'd63589;
			7'd77: v = 17'd63856;
			7'd78: v = 17'd64104;
			7'd79: v = 17'd64332;
			7'd80: v = 17'd64540;
			7'd81: v = 17'd64729;
			7'd82: v = 17'd64898;
			7'd83: v = 17'd65048;
			7'd84: v = 17'd65177;
			7'd85: v = 17'd65287;
			7'd86: v = 17'd65376;
			7'd87: v = 17'd65446;
			7'd88: v = 17'd65496;
			7'd89: v = 17'd65525;
			7'd90: v = 17'd65536;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic [TRIG_MAG_W-1:0] trig_mag(input logic [IDX_W-1:0] k);
		logic [47:0] v;
		v = 48'(quarter_sine(k));
		if (TRIG_FRAC_BITS >= 16) begin
			v = v << TRIG_UP;
		end else begin
			v = (v + (48'd1 << (TRIG_DN - 1))) >> TRIG_DN;
		end
		return v[TRIG_MAG_W-1:0];
	endfunction

endpackage

// ===== src/arx_angle.sv =====
module arx_angle (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [arx_pkg::ANGLE_W-1:0]  angle_deg,
	input  arx_pkg::coord_t                     coord_x,
	input  arx_pkg::coord_t                     coord_y,
	output arx_pkg::arx_trig_t                  trig
);
	import arx_pkg::*;

	logic [AOFF_W-1:0] a_off;
	logic [DEG_W-1:0]  deg;
	logic [IDX_W-1:0]  rem;
	logic [IDX_W-1:0]  sin_idx;
	logic [IDX_W-1:0]  cos_idx;
	logic              sin_neg;
	logic              cos_neg;

	logic              vld_s1, vld_s2, vld_s3;
	logic [DEG_W-1:0]  deg_s1;
	coord_t            x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic [IDX_W-1:0]  sin_idx_s2, cos_idx_s2;
	logic              sin_neg_s2, cos_neg_s2;
	trig_t             sin_s3, cos_s3;

	// bias into positive range, then fold by whole turns
	assign a_off = AOFF_W'($signed({angle_deg[ANGLE_W-1], angle_deg})
		+ $signed(AOFF_W'(ANGLE_BIAS)));

	always_comb begin
		if (a_off >= AOFF_W'(5 * DEG_FULL)) begin
			deg = DEG_W'(a_off - AOFF_W'(5 * DEG_FULL));
		end else if (a_off >= AOFF_W'(4 * DEG_FULL)) begin
			deg = DEG_W'(a_off - AOFF_W'(4 * DEG_FULL));
		end else if (a_off >= AOFF_W'(3 * DEG_FULL)) begin
			deg = DEG_W'(a_off - AOFF_W'(3 * DEG_FULL));
		end else if (a_off >= AOFF_W'(2 * DEG_FULL)) begin
			deg = DEG_W'(a_off - AOFF_W'(2 * DEG_FULL));
		end else if (a_off >= AOFF_W'(DEG_FULL)) begin
			deg = DEG_W'(a_off - AOFF_W'(DEG_FULL));
		end else begin
			deg = DEG_W'(a_off);
		end
	end

	always_comb begin
		if (deg_s1 >= DEG_W'(DEG_THREEQ)) begin
			rem     = IDX_W'(deg_s1 - DEG_W'(DEG_THREEQ));
			sin_neg = 1'b1;
			cos_neg = 1'b0;
		end else if (deg_s1 >= DEG_W'(DEG_HALF)) begin
			rem     = IDX_W'(deg_s1 - DEG_W'(DEG_HALF));
			sin_neg = 1'b1;
			cos_neg = 1'b1;
		end else if (deg_s1 >= DEG_W'(DEG_QUARTER)) begin
			rem     = IDX_W'(deg_s1 - DEG_W'(DEG_QUARTER));
			sin_neg = 1'b0;
			cos_neg = 1'b1;
		end else begin
			rem     = IDX_W'(deg_s1);
			sin_neg = 1'b0;
			cos_neg = 1'b0;
		end
		// odd quadrants swap the table reads
		if (sin_neg ^ cos_neg) begin
			sin_idx = IDX_W'(DEG_QUARTER) - rem;
			cos_idx = rem;
		end else begin
			sin_idx = rem;
			cos_idx = IDX_W'(DEG_QUARTER) - rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		deg_s1     <= deg;
		x_s1       <= coord_x;
		y_s1       <= coord_y;
		sin_idx_s2 <= sin_idx;
		cos_idx_s2 <= cos_idx;
		sin_neg_s2 <= sin_neg;
		cos_neg_s2 <= cos_neg;
		x_s2       <= x_s1;
		y_s2       <= y_s1;
		sin_s3     <= sin_neg_s2 ? -$signed({1'b0, trig_mag(sin_idx_s2)})
			: $signed({1'b0, trig_mag(sin_idx_s2)});
		cos_s3     <= cos_neg_s2 ? -$signed({1'b0, trig_mag(cos_idx_s2)})
			: $signed({1'b0, trig_mag(cos_idx_s2)});
		x_s3       <= x_s2;
		y_s3       <= y_s2;
	end

	assign trig.vld   = vld_s3;
	assign trig.sin_v = sin_s3;
	assign trig.cos_v = cos_s3;
	assign trig.x     = x_s3;
	assign trig.y     = y_s3;

endmodule

// ===== src/arx_mac.sv =====
module arx_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  arx_pkg::arx_trig_t trig,
	output arx_pkg::arx_sum_t  sums
);
	import arx_pkg::*;

	logic                     vld_s4, vld_s5;
	logic signed [PROD_W-1:0] xc_s4, xs_s4, yc_s4, ys_s4;
	sum_t                     sx_s5, sy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= trig.vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		xc_s4 <= trig.x * trig.cos_v;
		xs_s4 <= trig.x * trig.sin_v;
		yc_s4 <= trig.y * trig.cos_v;
		ys_s4 <= trig.y * trig.sin_v;
		sx_s5 <= SUM_W'(ys_s4) - SUM_W'(xc_s4);
		sy_s5 <= SUM_W'(xs_s4) + SUM_W'(yc_s4);
	end

	assign sums.vld   = vld_s5;
	assign sums.sum_x = sx_s5;
	assign sums.sum_y = sy_s5;

endmodule

// ===== src/arx_round.sv =====
module arx_round (
	input  logic              clk,
	input  logic              arst_n,
	input  arx_pkg::arx_sum_t sums,
	output logic              done,
	output arx_pkg::res_t     out_x,
	output arx_pkg::res_t     out_y
);
	import arx_pkg::*;

	function automatic logic [RND_W-1:0] round_mag(input logic [SUM_W-1:0] mag);
		logic [SUM_W:0] t;
		t = {1'b0, mag} + ((SUM_W + 1)'(1) << (FRAC_W - 1));
		return t[SUM_W:FRAC_W];
	endfunction

	function automatic res_t saturate(input logic neg, input logic [RND_W-1:0] m);
		logic [CMP_W-1:0] w;
		logic [OUT_W-1:0] lim;
		w = CMP_W'(m);
		if (neg) begin
			lim = (w > CMP_W'(OUT_MIN_MAG)) ? OUT_W'(OUT_MIN_MAG) : w[OUT_W-1:0];
			return -$signed(lim);
		end else begin
			lim = (w > CMP_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : w[OUT_W-1:0];
			return $signed(lim);
		end
	endfunction

	logic             vld_s6, vld_s7, vld_s8;
	logic             nx_s6, ny_s6, nx_s7, ny_s7;
	logic [SUM_W-1:0] mx_s6, my_s6;
	logic [RND_W-1:0] rx_s7, ry_s7;
	res_t             ox_s8, oy_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s6 <= sums.vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// round half away from zero on the magnitude
	always_ff @(posedge clk) begin
		nx_s6 <= sums.sum_x[SUM_W-1];
		ny_s6 <= sums.sum_y[SUM_W-1];
		mx_s6 <= sums.sum_x[SUM_W-1] ? SUM_W'(-sums.sum_x) : SUM_W'(sums.sum_x);
		my_s6 <= sums.sum_y[SUM_W-1] ? SUM_W'(-sums.sum_y) : SUM_W'(sums.sum_y);
		nx_s7 <= nx_s6;
		ny_s7 <= ny_s6;
		rx_s7 <= round_mag(mx_s6);
		ry_s7 <= round_mag(my_s6);
		ox_s8 <= saturate(nx_s7, rx_s7);
		oy_s8 <= saturate(ny_s7, ry_s7);
	end

	assign done  = vld_s8;
	assign out_x = ox_s8;
	assign out_y = oy_s8;

endmodule

// ===== src/angle_reflect_transform_2d.sv =====
// channel   handshake           word
// input     start (busy = 0)    angle_deg, coord_x, coord_y
// result    done                out_x, out_y
//
// One word accepted every cycle; busy is held low.
// A result shows on done after its word passes the eight register
// stages: angle fold, quadrant, sine table, multipliers, sums,
// magnitude, rounding, saturation.
// Reset clears the valid bits only; the receiver cannot stall.
module angle_reflect_transform_2d (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [arx_pkg::ANGLE_W-1:0] angle_deg,
	input  arx_pkg::coord_t                    coord_x,
	input  arx_pkg::coord_t                    coord_y,
	output logic                               done,
	output arx_pkg::res_t                      out_x,
	output arx_pkg::res_t                      out_y
);
	import arx_pkg::*;

	arx_trig_t trig;
	arx_sum_t  sums;

	assign busy = 1'b0;

	arx_angle u_angle (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start),
		.angle_deg (angle_deg),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.trig      (trig)
	);

	arx_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.trig   (trig),
		.sums   (sums)
	);

	arx_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.sums   (sums),
		.done   (done),
		.out_x  (out_x),
		.out_y  (out_y)
	);

endmodule

// ===== tb/angle_reflect_transform_2d_tb.sv =====
`timescale 1ns / 1ps

module angle_reflect_transform_2d_tb;

	import arx_pkg::*;

	localparam int RANDOM_WORDS = 900;
	localparam int PIPE_DEPTH   = 8;
	localparam int STALL_LIMIT  = 1000;

	typedef struct {
		logic signed [ANGLE_W-1:0] angle;
		coord_t                    x;
		coord_t                    y;
		bit                        drain;
	} point_word_t;

	typedef struct {
		res_t ox;
		res_t oy;
	} reflected_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic signed [ANGLE_W-1:0] angle_deg = '0;
	coord_t                    coord_x = '0;
	coord_t                    coord_y = '0;
	logic                      done;
	res_t                      out_x;
	res_t                      out_y;

	point_word_t pending_words[$];
	reflected_t  expected_pts[$];
	int          n_accepted;
	int          n_results;
	int          n_errors;
	int          idle_cycles;
	int          gap_left;
	int          burst_left;
	bit          took;
	point_word_t next_word;
	reflected_t  exp_pt;

	int unsigned sine_q[0:90] = '{
		0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
		11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
		22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
		32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
		42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
		50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
		56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
		61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
		64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65525,
		65536
	};

	angle_reflect_transform_2d u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.angle_deg (angle_deg),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.done      (done),
		.out_x     (out_x),
		.out_y     (out_y)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint trig_val(int k, bit neg);
		longint v;
		v = longint'(sine_q[k]);
		if (TRIG_FRAC_BITS >= 16) begin
			v = v <<< ((TRIG_FRAC_BITS >= 16) ? TRIG_FRAC_BITS - 16 : 0);
		end else begin
			v = (v + (64'sd1 <<< ((TRIG_FRAC_BITS < 16) ? 15 - TRIG_FRAC_BITS : 0)))
				>>> ((TRIG_FRAC_BITS < 16) ? 16 - TRIG_FRAC_BITS : 0);
		end
		return neg ? -v : v;
	endfunction

	function automatic res_t round_sat(longint s);
		longint m;
		bit     neg;
		neg = s < 0;
		m = neg ? -s : s;
		m = (m + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
		if (m > OUT_MIN_MAG)
			m = OUT_MIN_MAG;
		if (neg)
			m = -m;
		if (m > OUT_MAX)
			m = OUT_MAX;
		return res_t'(m);
	endfunction

	function automatic reflected_t reflect_point(logic signed [ANGLE_W-1:0] angle,
			coord_t x, coord_t y);
		int         a;
		int         r;
		longint     s;
		longint     c;
		longint     lx;
		longint     ly;
		reflected_t p;
		a = int'(angle) % DEG_FULL;
		if (a < 0)
			a += DEG_FULL;
		r = a % DEG_QUARTER;
		case (a / DEG_QUARTER)
			0: begin
				s = trig_val(r, 1'b0);
				c = trig_val(DEG_QUARTER - r, 1'b0);
			end
			1: begin
				s = trig_val(DEG_QUARTER - r, 1'b0);
				c = trig_val(r, 1'b1);
			end
			2: begin
				s = trig_val(r, 1'b1);
				c = trig_val(DEG_QUARTER - r, 1'b1);
			end
			default: begin
				s = trig_val(DEG_QUARTER - r, 1'b1);
				c = trig_val(r, 1'b0);
			end
		endcase
		lx = longint'(x);
		ly = longint'(y);
		p.ox = round_sat(-lx * c + ly * s);
		p.oy = round_sat(lx * s + ly * c);
		return p;
	endfunction

	function automatic coord_t rand_coord();
		logic [31:0] raw;
		int          r;
		raw = $urandom();
		r = $urandom_range(0, 99);
		if (r < 40)
			return coord_t'(raw);
		if (r < 60)
			return coord_t'(int'($urandom_range(0, 8191)) - 4096);
		if (r < 75) begin
			case ($urandom_range(0, 4))
				0: return coord_t'(-8388608);
				1: return coord_t'(8388607);
				2: return coord_t'(0);
				3: return coord_t'(-1);
				default: return coord_t'(1);
			endcase
		end
		return coord_t'({raw[23:8], 8'h80});
	endfunction

	function automatic point_word_t rand_word(bit drain);
		point_word_t w;
		int          k;
		if ($urandom_range(0, 99) < 70) begin
			w.angle = ANGLE_W'($urandom_range(0, 2047));
		end else begin
			k = int'($urandom_range(0, 22)) - 11;
			w.angle = ANGLE_W'(DEG_QUARTER * k + int'($urandom_range(0, 2)) - 1);
		end
		w.x = rand_coord();
		w.y = rand_coord();
		w.drain = drain;
		return w;
	endfunction

	function automatic point_word_t mk_word(int a, int x, int y);
		point_word_t w;
		w.angle = ANGLE_W'(a);
		w.x = coord_t'(x);
		w.y = coord_t'(y);
		w.drain = 1'b0;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			angle_deg <= '0;
			coord_x <= '0;
			coord_y <= '0;
			n_accepted <= 0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			took = start && !busy;
			if (took) begin
				expected_pts.push_back(reflect_point(angle_deg, coord_x, coord_y));
				n_accepted <= n_accepted + 1;
				if (burst_left > 0) begin
					burst_left--;
					gap_left = 0;
				end else begin
					case ($urandom_range(0, 99)) inside
						[0:2]:   begin
							burst_left = $urandom_range(20, 60);
							gap_left = 0;
						end
						[3:49]:  gap_left = 0;
						[50:87]: gap_left = $urandom_range(1, 3);
						[88:96]: gap_left = $urandom_range(4, 9);
						default: gap_left = $urandom_range(12, 40);
					endcase
				end
			end
			if (start && !took) begin
				// hold the word until busy drops
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_words.size() != 0 && !(pending_words[0].drain
					&& n_results != n_accepted + int'(took))) begin
				next_word = pending_words.pop_front();
				start <= 1'b1;
				angle_deg <= next_word.angle;
				coord_x <= next_word.x;
				coord_y <= next_word.y;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_results <= 0;
		end else if (done) begin
			if (n_results == n_accepted) begin
				$display("%0t: result with no word pending: out_x %0d out_y %0d",
					$time, out_x, out_y);
				n_errors++;
			end else begin
				exp_pt = expected_pts.pop_front();
				if (out_x !== exp_pt.ox) begin
					$display("%0t: out_x expected %0d actual %0d", $time, exp_pt.ox, out_x);
					n_errors++;
				end
				if (out_y !== exp_pt.oy) begin
					$display("%0t: out_y expected %0d actual %0d", $time, exp_pt.oy, out_y);
					n_errors++;
				end
				n_results <= n_results + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("angle_reflect_transform_2d: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		n_errors = 0;
		idle_cycles = 0;

		// rounding ties at the axis angles, then wrap, quadrant edges and full scale
		pending_words.push_back(mk_word(0, 128, -128));
		pending_words.push_back(mk_word(0, -128, 128));
		pending_words.push_back(mk_word(0, 127, 129));
		pending_words.push_back(mk_word(180, 384, -384));
		pending_words.push_back(mk_word(90, 8388607, -8388608));
		pending_words.push_back(mk_word(-1024, -8388608, -8388608));
		pending_words.push_back(mk_word(1023, 8388607, 8388607));
		pending_words.push_back(mk_word(270, -8388608, 8388607));
		pending_words.push_back(mk_word(359, 8388607, -8388608));
		pending_words.push_back(mk_word(360, 1000, 2000));
		pending_words.push_back(mk_word(-1, -8388608, 8388607));
		pending_words.push_back(mk_word(-360, 256, 256));
		pending_words.push_back(mk_word(45, -8388608, -8388608));
		pending_words.push_back(mk_word(-90, 0, 0));
		pending_words.push_back(mk_word(1, 1, -1));
		pending_words.push_back(mk_word(89, 12345, -54321));
		pending_words.push_back(mk_word(91, -777777, 3333333));
		pending_words.push_back(mk_word(179, 4194304, -4194304));
		pending_words.push_back(mk_word(181, -5000000, -6000000));
		pending_words.push_back(mk_word(269, 7654321, 1234567));
		pending_words.push_back(mk_word(271, -1, 1));
		pending_words.push_back(mk_word(-359, 8388607, 0));
		pending_words.push_back(mk_word(720, -640, 640));
		pending_words.push_back(mk_word(-720, 8388607, -8388608));
		for (int i = 0; i < RANDOM_WORDS; i++)
			pending_words.push_back(rand_word(i == 0 || i == 300 || i == 600));

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_words.size() != 0 || start || n_results != n_accepted)
			@(posedge clk);
		repeat (2 * PIPE_DEPTH) @(posedge clk);

		$display("%0d points reflected and checked over the full angle range, both wrap", n_results);
		$display("directions, every quadrant edge, rounding ties and full-scale coordinates");
		if (n_errors == 0)
			$display("angle_reflect_transform_2d: match");
		else
			$display("angle_reflect_transform_2d: mismatch");
		$finish;
	end

endmodule

// ===== angle_reflect_transform_2d.f =====
src/arx_pkg.sv
src/arx_angle.sv
src/arx_mac.sv
src/arx_round.sv
src/angle_reflect_transform_2d.sv
tb/angle_reflect_transform_2d_tb.sv
